/* rtl/bpsr_pkg.sv */
// shared types and constants for the bmp pixel stream to rgb565 converter
// no dependencies
`default_nettype none

package bpsr_pkg;

    localparam int MAX_IMAGE_SIDE = 2048;
    localparam int COORD_W        = 12;
    localparam int COUNT_W        = 11;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 40;

    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_RGB32  = 2'd3
    } fmt_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_FORMAT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_IMAGE_HEIGHT  = 3'd2,
        REG_WINDOW_LEFT   = 3'd3,
        REG_WINDOW_TOP    = 3'd4,
        REG_WINDOW_WIDTH  = 3'd5,
        REG_WINDOW_HEIGHT = 3'd6
    } cfg_reg_t;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_FOURTH = 2'd3;

    typedef struct packed {
        fmt_t               fmt;
        logic               oversize;
        logic [COORD_W-1:0] last_col_idx;
        logic [COORD_W-1:0] last_row_idx;
        logic [COORD_W-1:0] x_base;
        logic [COORD_W-1:0] y_base;
        logic [1:0]         pad_count;
    } cfg_derived_t;

    function automatic logic [15:0] bgr_to_565(input logic [7:0] b, input logic [7:0] g,
                                               input logic [7:0] r);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

/* rtl/bmp_pixel_stream_to_rgb565.sv */
// top level of the bmp pixel-array to rgb565 converter: input register, config, pixel path
// depends on bpsr_pkg, bpsr_cfg and bpsr_pixel
`default_nettype none

// Takes the raw pixel-array bytes of a bottom-up BMP image, one byte per word, and
// returns one RGB565 pixel with its screen coordinates when the last byte of a pixel
// arrives; row padding and the alpha byte of 32-bit pixels give no output, and an image
// larger than the window is dropped whole. The block sustains one byte per clock while
// the output is not stalled: a byte is captured in an input register and then processed
// by a single stage that updates the counters and loads the output register, and a
// waiting output stalls the input only when the input register is also full. Registers
// are to be written by the user through the cfg port only while no byte is in flight;
// the block itself does not enforce this. Derived window offsets are registered and
// settle in the cycle after a write.
module bmp_pixel_stream_to_rgb565 (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [bpsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [bpsr_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] data_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bpsr_pkg::OUT_DATA_W-1:0]          m_tdata,   // [11:0] screen_x,
                                                                // [23:12] screen_y,
                                                                // [39:24] rgb565
    output logic                                     m_tlast    // image_done
);

    bpsr_pkg::cfg_derived_t derived;

    logic                              in_valid_reg, in_valid_next;
    logic [bpsr_pkg::IN_DATA_W-1:0]    in_byte_reg;
    logic                              word_take;

    bpsr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .derived   (derived)
    );

    assign s_tready = !in_valid_reg || word_take;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (word_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    bpsr_pixel u_pixel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .derived    (derived),
        .word_valid (in_valid_reg),
        .word_byte  (in_byte_reg),
        .word_take  (word_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/bpsr_cfg.sv */
// configuration registers and the per-image values derived from them
// depends on bpsr_pkg
`default_nettype none

module bpsr_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [bpsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bpsr_pkg::cfg_derived_t                   derived
);

    localparam int CW = bpsr_pkg::COORD_W;
    localparam logic [CW:0] MAX_SIDE = (CW+1)'(bpsr_pkg::MAX_IMAGE_SIDE);

    bpsr_pkg::fmt_t  pixel_format_reg;
    logic [CW-1:0]   image_width_reg;
    logic [CW-1:0]   image_height_reg;
    logic [CW-1:0]   window_left_reg;
    logic [CW-1:0]   window_top_reg;
    logic [CW-1:0]   window_width_reg;
    logic [CW-1:0]   window_height_reg;

    bpsr_pkg::cfg_derived_t derived_reg;
    bpsr_pkg::cfg_derived_t derived_next;

    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg  <= bpsr_pkg::FMT_RGB24;
            image_width_reg   <= CW'(1);
            image_height_reg  <= CW'(1);
            window_left_reg   <= '0;
            window_top_reg    <= '0;
            window_width_reg  <= CW'(240);
            window_height_reg <= CW'(320);
        end else if (cfg_we) begin
            case (cfg_index)
                bpsr_pkg::REG_PIXEL_FORMAT:  pixel_format_reg  <= bpsr_pkg::fmt_t'(cfg_wdata[1:0]);
                bpsr_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[CW-1:0];
                bpsr_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata[CW-1:0];
                bpsr_pkg::REG_WINDOW_LEFT:   window_left_reg   <= cfg_wdata[CW-1:0];
                bpsr_pkg::REG_WINDOW_TOP:    window_top_reg    <= cfg_wdata[CW-1:0];
                bpsr_pkg::REG_WINDOW_WIDTH:  window_width_reg  <= cfg_wdata[CW-1:0];
                bpsr_pkg::REG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = CW'(1);
        end else if ({1'b0, image_width_reg} > MAX_SIDE) begin
            w_eff = MAX_SIDE[CW-1:0];
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_eff = CW'(1);
        end else if ({1'b0, image_height_reg} > MAX_SIDE) begin
            h_eff = MAX_SIDE[CW-1:0];
        end else begin
            h_eff = image_height_reg;
        end

        derived_next.fmt          = pixel_format_reg;
        derived_next.oversize     = (w_eff > window_width_reg) || (h_eff > window_height_reg);
        derived_next.last_col_idx = w_eff - CW'(1);
        derived_next.last_row_idx = h_eff - CW'(1);
        derived_next.x_base       = window_left_reg + ((window_width_reg - w_eff) >> 1);
        derived_next.y_base       = window_top_reg + ((window_height_reg - h_eff) >> 1)
                                    + h_eff - CW'(1);
        // row padding to a 4-byte boundary
        case (pixel_format_reg)
            bpsr_pkg::FMT_RGB555,
            bpsr_pkg::FMT_RGB565: derived_next.pad_count = {w_eff[0], 1'b0};
            bpsr_pkg::FMT_RGB24:  derived_next.pad_count = w_eff[1:0];
            default:              derived_next.pad_count = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        derived_reg <= derived_next;
    end

    assign derived = derived_reg;

endmodule

`default_nettype wire

/* rtl/bpsr_pixel.sv */
// pixel assembly, row and column counters and the result register
// depends on bpsr_pkg
`default_nettype none

module bpsr_pixel (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire bpsr_pkg::cfg_derived_t              derived,
    input  wire logic                                word_valid,
    input  wire logic [bpsr_pkg::IN_DATA_W-1:0]      word_byte,
    output logic                                     word_take,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bpsr_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                     m_tlast
);

    localparam int CW = bpsr_pkg::COORD_W;
    localparam int NW = bpsr_pkg::COUNT_W;

    logic [1:0]    byte_phase_reg,    byte_phase_next;
    logic [15:0]   partial_pixel_reg, partial_pixel_next;
    logic [NW-1:0] column_count_reg,  column_count_next;
    logic [NW-1:0] row_count_reg,     row_count_next;
    logic [1:0]    padding_left_reg,  padding_left_next;
    logic          out_valid_reg,     out_valid_next;
    logic [CW-1:0] out_x_reg,         out_x_next;
    logic [CW-1:0] out_y_reg,         out_y_next;
    logic [15:0]   out_color_reg,     out_color_next;
    logic          out_done_reg,      out_done_next;

    logic        complete;
    logic [15:0] color;
    logic [15:0] raw16;
    logic        last_col;
    logic        last_row;

    assign word_take = word_valid && (!out_valid_reg || m_tready);
    assign raw16     = {word_byte, partial_pixel_reg[7:0]};
    assign last_col  = {1'b0, column_count_reg} >= derived.last_col_idx;
    assign last_row  = {1'b0, row_count_reg} >= derived.last_row_idx;

    always_comb begin
        byte_phase_next    = byte_phase_reg;
        partial_pixel_next = partial_pixel_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        padding_left_next  = padding_left_reg;
        complete           = 1'b0;
        color              = raw16;

        if (word_take && !derived.oversize) begin
            if (padding_left_reg != 2'd0) begin
                padding_left_next = padding_left_reg - 2'd1;
            end else if (byte_phase_reg == bpsr_pkg::PHASE_FIRST) begin
                partial_pixel_next = {8'h00, word_byte};
                byte_phase_next    = bpsr_pkg::PHASE_SECOND;
            end else begin
                case (derived.fmt)
                    bpsr_pkg::FMT_RGB555: begin
                        complete = 1'b1;
                        color    = {raw16[14:5], 1'b0, raw16[4:0]};
                    end
                    bpsr_pkg::FMT_RGB565: begin
                        complete = 1'b1;
                        color    = raw16;
                    end
                    bpsr_pkg::FMT_RGB24: begin
                        if (byte_phase_reg == bpsr_pkg::PHASE_SECOND) begin
                            partial_pixel_next = raw16;
                            byte_phase_next    = bpsr_pkg::PHASE_THIRD;
                        end else begin
                            complete = 1'b1;
                            color    = bpsr_pkg::bgr_to_565(partial_pixel_reg[7:0],
                                           partial_pixel_reg[15:8], word_byte);
                        end
                    end
                    default: begin
                        if (byte_phase_reg == bpsr_pkg::PHASE_SECOND) begin
                            partial_pixel_next = raw16;
                            byte_phase_next    = bpsr_pkg::PHASE_THIRD;
                        end else if (byte_phase_reg == bpsr_pkg::PHASE_THIRD) begin
                            partial_pixel_next = bpsr_pkg::bgr_to_565(partial_pixel_reg[7:0],
                                                     partial_pixel_reg[15:8], word_byte);
                            byte_phase_next    = bpsr_pkg::PHASE_FOURTH;
                        end else begin
                            // alpha byte dropped
                            complete = 1'b1;
                            color    = partial_pixel_reg;
                        end
                    end
                endcase

                if (complete) begin
                    byte_phase_next = bpsr_pkg::PHASE_FIRST;
                    if (last_col) begin
                        column_count_next = '0;
                        padding_left_next = derived.pad_count;
                        row_count_next    = last_row ? '0 : row_count_reg + NW'(1);
                    end else begin
                        column_count_next = column_count_reg + NW'(1);
                    end
                end
            end
        end

        out_x_next     = derived.x_base + CW'(column_count_reg);
        out_y_next     = derived.y_base - CW'(row_count_reg);
        out_color_next = color;
        out_done_next  = last_col && last_row;

        if (complete) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_phase_reg    <= bpsr_pkg::PHASE_FIRST;
            partial_pixel_reg <= '0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            padding_left_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            byte_phase_reg    <= byte_phase_next;
            partial_pixel_reg <= partial_pixel_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            padding_left_reg  <= padding_left_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (complete) begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_color_reg <= out_color_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

/* rtl/bpsr_checker.sv */
// port-level checks for bmp_pixel_stream_to_rgb565, attached by bind
// depends on bpsr_pkg
`default_nettype none

module bpsr_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [bpsr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input wire logic                                m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_result_has_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("pixel without a byte accepted two cycles earlier");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

endmodule

bind bmp_pixel_stream_to_rgb565 bpsr_checker u_bpsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/bmp_pixel_stream_to_rgb565_tb.sv */
// testbench for bmp_pixel_stream_to_rgb565: feeds bmp pixel-array bytes and checks each
// rgb565 pixel, its screen coordinates and the image-done flag against a local predictor
// depends on bpsr_pkg and the rtl top level
`default_nettype none

module bmp_pixel_stream_to_rgb565_tb;

    localparam logic [bpsr_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 560;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] rgb;
        logic        done;
    } pixel_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [bpsr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bpsr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [bpsr_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [bpsr_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             m_tlast;

    bmp_pixel_stream_to_rgb565 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of the registers
    bpsr_pkg::fmt_t cur_fmt  = bpsr_pkg::FMT_RGB24;
    logic [11:0]    img_w    = 12'd1;
    logic [11:0]    img_h    = 12'd1;
    logic [11:0]    win_left = 12'd0;
    logic [11:0]    win_top  = 12'd0;
    logic [11:0]    win_w    = 12'd240;
    logic [11:0]    win_h    = 12'd320;

    // predictor copy of the pixel assembly state
    logic [1:0]  beat_idx   = bpsr_pkg::PHASE_FIRST;
    logic [15:0] held_color = '0;
    logic [10:0] col_pos    = '0;
    logic [10:0] row_pos    = '0;
    logic [1:0]  pad_todo   = '0;

    pixel_t pixel_q[$];

    int  error_count   = 0;
    int  bytes_used    = 0;
    int  pixels_seen   = 0;
    int  settings_done = 0;
    int  quiet_cycles  = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;
    bit  idle_on       = 1'b1;

    function automatic int side_limit(input int v);
        if (v < 1) return 1;
        if (v > bpsr_pkg::MAX_IMAGE_SIDE) return bpsr_pkg::MAX_IMAGE_SIDE;
        return v;
    endfunction

    function automatic int bytes_per_pixel(input bpsr_pkg::fmt_t f);
        if (f == bpsr_pkg::FMT_RGB555 || f == bpsr_pkg::FMT_RGB565) return 2;
        if (f == bpsr_pkg::FMT_RGB24) return 3;
        return 4;
    endfunction

    function automatic int row_pad_bytes(input int w);
        return (4 - ((w * bytes_per_pixel(cur_fmt)) & 3)) & 3;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic convert_byte(input logic [7:0] b);
        logic [11:0] w, h;
        logic [15:0] color;
        logic [31:0] sx, sy;
        logic        lc, lr;
        pixel_t      p;
        w = 12'(side_limit(int'(img_w)));
        h = 12'(side_limit(int'(img_h)));
        if (w > win_w || h > win_h) return;
        bytes_used++;
        if (pad_todo != 2'd0) begin
            pad_todo = pad_todo - 2'd1;
            return;
        end
        if (cur_fmt == bpsr_pkg::FMT_RGB555 || cur_fmt == bpsr_pkg::FMT_RGB565) begin
            if (beat_idx == bpsr_pkg::PHASE_FIRST) begin
                held_color = {8'd0, b};
                beat_idx   = bpsr_pkg::PHASE_SECOND;
                return;
            end
            color = {b, held_color[7:0]};
            if (cur_fmt == bpsr_pkg::FMT_RGB555)
                color = {color[14:5], 1'b0, color[4:0]};
        end else begin
            if (beat_idx == bpsr_pkg::PHASE_FIRST) begin
                held_color = {8'd0, b};
                beat_idx   = bpsr_pkg::PHASE_SECOND;
                return;
            end
            if (beat_idx == bpsr_pkg::PHASE_SECOND) begin
                held_color = {b, held_color[7:0]};
                beat_idx   = bpsr_pkg::PHASE_THIRD;
                return;
            end
            if (cur_fmt == bpsr_pkg::FMT_RGB32 && beat_idx == bpsr_pkg::PHASE_THIRD) begin
                held_color = pack565(held_color[7:0], held_color[15:8], b);
                beat_idx   = bpsr_pkg::PHASE_FOURTH;
                return;
            end
            if (cur_fmt == bpsr_pkg::FMT_RGB32)
                color = held_color;
            else
                color = pack565(held_color[7:0], held_color[15:8], b);
        end
        sx = 32'(win_left) + 32'((win_w - w) >> 1) + 32'(col_pos);
        sy = 32'(win_top) + 32'((win_h - h) >> 1) + 32'(h) - 32'd1 - 32'(row_pos);
        lc = ({1'b0, col_pos} >= w - 12'd1);
        lr = ({1'b0, row_pos} >= h - 12'd1);
        p.x    = sx[11:0];
        p.y    = sy[11:0];
        p.rgb  = color;
        p.done = lc && lr;
        pixel_q.push_back(p);
        beat_idx = bpsr_pkg::PHASE_FIRST;
        if (lc) begin
            col_pos  = '0;
            pad_todo = 2'(row_pad_bytes(int'(w)));
            row_pos  = lr ? 11'd0 : row_pos + 11'd1;
        end else begin
            col_pos = col_pos + 11'd1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        convert_byte(b);
    endtask

    task automatic send_rows(input int nrows);
        int w, bpp, pad;
        w   = side_limit(int'(img_w));
        bpp = bytes_per_pixel(cur_fmt);
        pad = row_pad_bytes(w);
        repeat (nrows) begin
            repeat (w * bpp) push_byte(8'($urandom));
            repeat (pad) push_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_wr(input logic [bpsr_pkg::CFG_INDEX_W-1:0] idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            bpsr_pkg::REG_PIXEL_FORMAT:  cur_fmt  = bpsr_pkg::fmt_t'(val[1:0]);
            bpsr_pkg::REG_IMAGE_WIDTH:   img_w    = val;
            bpsr_pkg::REG_IMAGE_HEIGHT:  img_h    = val;
            bpsr_pkg::REG_WINDOW_LEFT:   win_left = val;
            bpsr_pkg::REG_WINDOW_TOP:    win_top  = val;
            bpsr_pkg::REG_WINDOW_WIDTH:  win_w    = val;
            bpsr_pkg::REG_WINDOW_HEIGHT: win_h    = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input bpsr_pkg::fmt_t f, input int iw, input int ih,
                                input int wl, input int wt, input int ww, input int wh);
        wait_idle();
        cfg_wr(REG_UNUSED, 12'($urandom));
        cfg_wr(bpsr_pkg::REG_PIXEL_FORMAT, {10'($urandom), f});
        cfg_wr(bpsr_pkg::REG_IMAGE_WIDTH, 12'(iw));
        cfg_wr(bpsr_pkg::REG_IMAGE_HEIGHT, 12'(ih));
        cfg_wr(bpsr_pkg::REG_WINDOW_LEFT, 12'(wl));
        cfg_wr(bpsr_pkg::REG_WINDOW_TOP, 12'(wt));
        cfg_wr(bpsr_pkg::REG_WINDOW_WIDTH, 12'(ww));
        cfg_wr(bpsr_pkg::REG_WINDOW_HEIGHT, 12'(wh));
        cfg_we <= 1'b0;
        repeat (2) @(posedge aclk);
        settings_done++;
    endtask

    initial begin : result_sink
        int     stall;
        pixel_t want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected word", {m_tdata[38:0], m_tlast}, '0);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[11:0] != want.x)
                        report_mismatch("screen_x", 40'(m_tdata[11:0]), 40'(want.x));
                    if (m_tdata[23:12] != want.y)
                        report_mismatch("screen_y", 40'(m_tdata[23:12]), 40'(want.y));
                    if (m_tdata[39:24] != want.rgb)
                        report_mismatch("rgb565", 40'(m_tdata[39:24]), 40'(want.rgb));
                    if (m_tlast != want.done)
                        report_mismatch("image_done", 40'(m_tlast), 40'(want.done));
                end
                stall = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
    end

    task automatic test_reset_defaults();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
    endtask

    task automatic test_pixel_formats();
        apply_config(bpsr_pkg::FMT_RGB555, 1, 1, 0, 0, 1, 1);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'h00);
        push_byte(8'hFF);
        // zero width reads as one, window at the far corner
        apply_config(bpsr_pkg::FMT_RGB565, 0, 1, 4095, 4095, 2, 2);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h5A);
        push_byte(8'hA5);
        apply_config(bpsr_pkg::FMT_RGB32, 1, 1, 0, 0, 4095, 4095);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
    endtask

    task automatic test_oversize_and_clamp();
        apply_config(bpsr_pkg::FMT_RGB24, 3, 1, 100, 100, 2, 320);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'h56);
        apply_config(bpsr_pkg::FMT_RGB24, 1, 1, 0, 0, 0, 0);
        push_byte(8'hFF);
        // sizes above the maximum clamp; leaves the image part way through a row
        apply_config(bpsr_pkg::FMT_RGB565, 4095, 4095, 0, 0, 4095, 4095);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
    endtask

    task automatic test_backpressure();
        apply_config(bpsr_pkg::FMT_RGB565, 8, 8, $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(8, 4095),
                     $urandom_range(8, 4095));
        idle_on      = 1'b0;
        hold_request = 1'b1;
        send_rows(8);
        idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_random();
        int             start, kind, iw, ih, w_eff, h_eff, ww, wh;
        bpsr_pkg::fmt_t f;
        start = bytes_used;
        while (bytes_used - start < RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            f    = bpsr_pkg::fmt_t'($urandom_range(0, 3));
            iw   = $urandom_range(1, 9);
            ih   = $urandom_range(1, 6);
            if (kind == 0) iw = 0;
            if (kind == 1) ih = 0;
            if (kind == 2) iw = $urandom_range(2048, 4095);
            w_eff = side_limit(iw);
            h_eff = side_limit(ih);
            ww = $urandom_range(0, 1) ? w_eff + $urandom_range(0, 8)
                                      : $urandom_range(w_eff, 4095);
            wh = $urandom_range(0, 1) ? h_eff + $urandom_range(0, 8)
                                      : $urandom_range(h_eff, 4095);
            if (kind == 3) begin
                if ($urandom_range(0, 1))
                    ww = $urandom_range(0, w_eff - 1);
                else
                    wh = $urandom_range(0, h_eff - 1);
            end
            apply_config(f, iw, ih, $urandom_range(0, 4095), $urandom_range(0, 4095), ww, wh);
            idle_on = ($urandom_range(0, 3) != 0);
            if (kind == 2 || kind == 3) begin
                repeat ($urandom_range(3, 16)) push_byte(8'($urandom));
            end else begin
                send_rows(h_eff * $urandom_range(1, 2));
                if ($urandom_range(0, 2) == 0) begin
                    wait_idle();
                    send_rows(1);
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 7)) push_byte(8'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_pixel_formats();
        test_oversize_and_clamp();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (8) @(posedge aclk);
        $display("run covered %0d bytes over %0d register settings, %0d pixels compared",
                 bytes_used, settings_done, pixels_seen);
        $display("all four formats, row padding, clamped and oversize images, long stalls");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/bpsr_pkg.sv
rtl/bpsr_cfg.sv
rtl/bpsr_pixel.sv
rtl/bmp_pixel_stream_to_rgb565.sv
rtl/bpsr_checker.sv
tb/bmp_pixel_stream_to_rgb565_tb.sv
